@@ rtl/core/aes128_pkg.sv @@
`default_nettype none

package aes128_pkg;

    // Schedule size and derived row layout (one row = one 128-bit round key)
    localparam int KEY_WORDS  = 44;
    localparam int DATA_W     = 64;
    localparam int BLOCK_W    = 128;

    // Configuration port
    localparam int CFG_ADDR_W = 2;
    localparam logic [CFG_ADDR_W-1:0] REG_KEY_HIGH = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_KEY_LOW  = 2'd1;

    // Field constants
    localparam logic [7:0] GF_POLY    = 8'h1b;
    localparam logic [7:0] RCON_FIRST = 8'h01;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXPAND,
        ST_RUN
    } t_fsm;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    // Multiply by x in GF(2^8)
    function automatic logic [7:0] gf_double(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? GF_POLY : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    // Next 128-bit round key from the previous one
    function automatic logic [127:0] next_round_key(input logic [127:0] k,
                                                    input logic [7:0] rcon);
        logic [31:0] t;
        logic [31:0] n0, n1, n2, n3;
        t  = sub_word({k[23:0], k[31:24]}) ^ {rcon, 24'h0};
        n0 = k[127:96] ^ t;
        n1 = k[95:64] ^ n0;
        n2 = k[63:32] ^ n1;
        n3 = k[31:0] ^ n2;
        return {n0, n1, n2, n3};
    endfunction

    // SubBytes plus ShiftRows; byte i sits at bits [127-8i -: 8]
    function automatic logic [127:0] sub_shift(input logic [127:0] s);
        logic [127:0] t;
        int src;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                src = r + 4 * ((c + r) % 4);
                t[127 - 8 * (r + 4 * c) -: 8] = SBOX[s[127 - 8 * src -: 8]];
            end
        end
        return t;
    endfunction

    function automatic logic [127:0] mix_cols(input logic [127:0] s);
        logic [127:0] t;
        logic [7:0] a0, a1, a2, a3, all;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            a0  = s[127 - 32 * c -: 8];
            a1  = s[119 - 32 * c -: 8];
            a2  = s[111 - 32 * c -: 8];
            a3  = s[103 - 32 * c -: 8];
            all = a0 ^ a1 ^ a2 ^ a3;
            t[127 - 32 * c -: 8] = a0 ^ all ^ gf_double(a0 ^ a1);
            t[119 - 32 * c -: 8] = a1 ^ all ^ gf_double(a1 ^ a2);
            t[111 - 32 * c -: 8] = a2 ^ all ^ gf_double(a2 ^ a3);
            t[103 - 32 * c -: 8] = a3 ^ all ^ gf_double(a3 ^ a0);
        end
        return t;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/aes128_pt_if.sv @@
`default_nettype none

interface aes128_pt_if;
    logic                           valid;
    logic                           ready;
    logic [aes128_pkg::DATA_W-1:0]  pt_high;
    logic [aes128_pkg::DATA_W-1:0]  pt_low;

    modport source (output valid, output pt_high, output pt_low, input ready);
    modport sink   (input valid, input pt_high, input pt_low, output ready);
endinterface

`default_nettype wire

@@ rtl/core/aes128_ct_if.sv @@
`default_nettype none

interface aes128_ct_if;
    logic                           valid;
    logic                           ready;
    logic [aes128_pkg::DATA_W-1:0]  ct_high;
    logic [aes128_pkg::DATA_W-1:0]  ct_low;

    modport source (output valid, output ct_high, output ct_low, input ready);
    modport sink   (input valid, input ct_high, input ct_low, output ready);
endinterface

`default_nettype wire

@@ rtl/core/aes128_block_encrypt_core.sv @@
// A plaintext word runs an initial key add plus ten rounds, one round-key row per
//   round from the single read port of the round-key memory; the last round waits
//   while the output word register is still full, and a new word is taken with it.
// A key write rebuilds the schedule; no block is taken meanwhile.
// Reset (synchronous, active low) clears control and both key registers;
//   the round-key memory is not cleared and is valid once a key is written.
`default_nettype none

module aes128_block_encrypt_core #(
    parameter int P_KEY_WORDS = aes128_pkg::KEY_WORDS
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [aes128_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [aes128_pkg::DATA_W-1:0]     i_cfg_data,
    aes128_pt_if.sink                              i_pt,
    aes128_ct_if.source                            o_ct
);
    import aes128_pkg::*;

    localparam int ROWS  = P_KEY_WORDS / 4;
    localparam int LAST  = ROWS - 1;
    localparam int ROW_W = $clog2(ROWS);
    localparam logic [ROW_W-1:0] CNT_LAST = ROW_W'(LAST);
    localparam logic [ROW_W-1:0] CNT_ONE  = ROW_W'(1);

    // Control and key registers
    t_fsm                r_fsm, n_fsm;
    logic [ROW_W-1:0]    r_cnt;
    logic [DATA_W-1:0]   r_key_high, r_key_low;
    logic [BLOCK_W-1:0]  r_kexp;
    logic [7:0]          r_rcon;
    logic [BLOCK_W-1:0]  r_state;
    logic [BLOCK_W-1:0]  r_rd_data;
    logic                r_out_valid;
    logic [DATA_W-1:0]   r_ct_high, r_ct_low;

    // Round-key memory, one 128-bit row per round
    logic [BLOCK_W-1:0]  r_key_mem [ROWS];

    logic                w_cfg_hit;
    logic [DATA_W-1:0]   w_key_high_nx, w_key_low_nx;
    logic                w_out_free;
    logic                w_accept;
    logic                w_last_adv;
    logic                w_mem_we;
    logic                w_mem_re;
    logic [ROW_W-1:0]    w_raddr;
    logic                w_in_ready;
    logic [BLOCK_W-1:0]  w_round_in;
    logic [BLOCK_W-1:0]  w_round_out;

    // Key register write decode
    assign w_cfg_hit     = i_cfg_we && ((i_cfg_addr == REG_KEY_HIGH) ||
                                        (i_cfg_addr == REG_KEY_LOW));
    assign w_key_high_nx = (i_cfg_we && (i_cfg_addr == REG_KEY_HIGH)) ? i_cfg_data
                                                                       : r_key_high;
    assign w_key_low_nx  = (i_cfg_we && (i_cfg_addr == REG_KEY_LOW)) ? i_cfg_data
                                                                      : r_key_low;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
        end else begin
            r_key_high <= w_key_high_nx;
            r_key_low  <= w_key_low_nx;
        end
    end

    // Next state
    always_comb begin
        n_fsm = r_fsm;
        unique case (r_fsm)
            ST_IDLE: begin
                if (w_accept) n_fsm = ST_RUN;
            end
            ST_EXPAND: begin
                if (r_cnt == CNT_LAST) n_fsm = ST_IDLE;
            end
            ST_RUN: begin
                if (w_last_adv && !w_accept) n_fsm = ST_IDLE;
            end
            default: n_fsm = ST_IDLE;
        endcase
        if (w_cfg_hit) n_fsm = ST_EXPAND;
    end

    // Outputs of the sequencer
    always_comb begin
        w_out_free = !r_out_valid || o_ct.ready;
        w_in_ready = 1'b0;
        w_last_adv = 1'b0;
        w_mem_we   = 1'b0;
        w_mem_re   = 1'b0;
        w_raddr    = '0;
        unique case (r_fsm)
            ST_IDLE: begin
                w_in_ready = !i_cfg_we;
            end
            ST_EXPAND: begin
                w_mem_we = 1'b1;
            end
            ST_RUN: begin
                if (r_cnt == CNT_LAST) begin
                    w_last_adv = w_out_free;
                    w_in_ready = w_out_free && !i_cfg_we;
                end else begin
                    w_mem_re = 1'b1;
                    w_raddr  = r_cnt + CNT_ONE;
                end
            end
            default: ;
        endcase
        w_accept = w_in_ready && i_pt.valid;
        if (w_accept) begin
            w_mem_re = 1'b1;
            w_raddr  = '0;
        end
    end

    assign i_pt.ready = w_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_fsm <= ST_IDLE;
        else          r_fsm <= n_fsm;
    end

    // Row / round counter, shared by expansion and encryption
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (w_cfg_hit || w_accept) begin
            r_cnt <= '0;
        end else if (r_fsm == ST_EXPAND) begin
            r_cnt <= r_cnt + CNT_ONE;
        end else if (r_fsm == ST_RUN && r_cnt != CNT_LAST) begin
            r_cnt <= r_cnt + CNT_ONE;
        end
    end

    // Key expansion: one round key per cycle into the memory
    always_ff @(posedge i_clk) begin
        if (w_cfg_hit) begin
            r_kexp <= {w_key_high_nx, w_key_low_nx};
            r_rcon <= RCON_FIRST;
        end else if (r_fsm == ST_EXPAND) begin
            r_kexp <= next_round_key(r_kexp, r_rcon);
            r_rcon <= gf_double(r_rcon);
        end
    end

    // Memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_mem_we) r_key_mem[r_cnt] <= r_kexp;
        if (w_mem_re) r_rd_data <= r_key_mem[w_raddr];
    end

    // Round datapath: key add only, full round, or last round without mix
    always_comb begin
        if (r_cnt == '0)           w_round_in = r_state;
        else if (r_cnt == CNT_LAST) w_round_in = sub_shift(r_state);
        else                       w_round_in = mix_cols(sub_shift(r_state));
        w_round_out = w_round_in ^ r_rd_data;
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_state <= {i_pt.pt_high, i_pt.pt_low};
        end else if (r_fsm == ST_RUN && r_cnt != CNT_LAST) begin
            r_state <= w_round_out;
        end
    end

    // Output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_last_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_ct.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_last_adv) begin
            r_ct_high <= w_round_out[BLOCK_W-1:DATA_W];
            r_ct_low  <= w_round_out[DATA_W-1:0];
        end
    end

    assign o_ct.valid   = r_out_valid;
    assign o_ct.ct_high = r_ct_high;
    assign o_ct.ct_low  = r_ct_low;

    // A new result only comes out of the last round
    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_fsm == ST_RUN && r_cnt == CNT_LAST))
        else $error("result without last round");

    // Round zero is entered only by accepting a plaintext word
    a_round0_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fsm == ST_RUN && r_cnt == '0) |-> $past(i_pt.valid && i_pt.ready))
        else $error("round zero without accepted word");

    // No plaintext taken while the schedule is being rebuilt
    a_no_accept_expand: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fsm == ST_EXPAND) |-> !i_pt.ready)
        else $error("word accepted during key expansion");

    // Expansion ends after the last row unless a new key write restarts it
    a_expand_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fsm == ST_EXPAND && r_cnt == CNT_LAST && !w_cfg_hit) |=> (r_fsm == ST_IDLE))
        else $error("expansion did not finish");

endmodule

`default_nettype wire
